// ===== rtl/gwr_pkg.sv =====
`timescale 1ns / 1ps
package gwr_pkg;

    localparam int CFG_W   = 12;
    localparam int EPOCH_W = 8;
    localparam int POP_W   = 11;

    localparam logic [1:0] CFG_GRID_SIZE    = 2'd0;
    localparam logic [1:0] CFG_WALK_LIMIT   = 2'd1;
    localparam logic [1:0] CFG_SEARCH_LIMIT = 2'd2;

    localparam logic [1:0] ACT_START = 2'd0;
    localparam logic [1:0] ACT_STEP  = 2'd1;
    localparam logic [1:0] ACT_READ  = 2'd2;

    localparam logic [1:0] DIR_ROW_UP   = 2'd0;
    localparam logic [1:0] DIR_ROW_DOWN = 2'd1;
    localparam logic [1:0] DIR_COL_UP   = 2'd2;

    localparam logic [2:0] STS_ACCEPTED    = 3'd0;
    localparam logic [2:0] STS_REJECTED    = 3'd1;
    localparam logic [2:0] STS_FINISHED    = 3'd2;
    localparam logic [2:0] STS_ABORTED     = 3'd3;
    localparam logic [2:0] STS_NOT_STARTED = 3'd4;
    localparam logic [2:0] STS_OK          = 3'd5;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_WALK,
        PH_DONE,
        PH_ABORT
    } phase_t;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_CLEAR,
        ST_READ,
        ST_SRCH_INIT,
        ST_MARK_CLR,
        ST_POP,
        ST_POP_DATA,
        ST_CHECK,
        ST_ENQ,
        ST_RESP
    } fsm_t;

    typedef struct packed {
        logic [1:0] action;
        logic [1:0] direction;
        logic [3:0] read_row;
        logic [3:0] read_col;
    } in_req_t;

    typedef struct packed {
        logic [2:0] status;
        logic       finished;
        logic [3:0] pos_row;
        logic [3:0] pos_col;
        logic [8:0] path_count;
        logic [8:0] cell_value;
    } out_rsp_t;

    typedef struct packed {
        logic rd;
        logic num_we;
        logic tag_we;
        logic clr_num;
        logic clr_tag;
    } grid_ctl_t;

    typedef struct packed {
        logic clear;
        logic push;
        logic pop;
    } q_ctl_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_sts_t;

endpackage

// ===== rtl/gwr_queue.sv =====
`timescale 1ns / 1ps
module gwr_queue #(
    parameter int DEPTH = 4096,
    parameter int DW    = 12
) (
    input  logic            clk,
    input  logic            rst_n,
    input  gwr_pkg::q_ctl_t ctl,
    input  logic [DW-1:0]   wdata,
    output logic [DW-1:0]   rdata,
    output gwr_pkg::q_sts_t sts
);
    import gwr_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [DW-1:0] mem [DEPTH];
    logic [AW-1:0] head_reg, head_next;
    logic [AW-1:0] tail_reg, tail_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push, do_pop;

    // drop pushes while full
    assign do_push = ctl.push && (count_reg != CW'(DEPTH));
    assign do_pop  = ctl.pop && (count_reg != '0);

    assign sts.empty = (count_reg == '0);
    assign sts.full  = (count_reg == CW'(DEPTH));

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (ctl.clear)
        begin
            head_next  = '0;
            tail_next  = '0;
            count_next = '0;
        end
        else
        begin
            if (do_pop)
                head_next = (head_reg == AW'(DEPTH - 1)) ? '0 : head_reg + 1'b1;
            if (do_push)
                tail_next = (tail_reg == AW'(DEPTH - 1)) ? '0 : tail_reg + 1'b1;
            count_next = count_reg + CW'(do_push) - CW'(do_pop);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push && !ctl.clear)
            mem[tail_reg] <= wdata;
        if (do_pop && !ctl.clear)
            rdata <= mem[head_reg];
    end

endmodule

// ===== rtl/gwr_grid.sv =====
`timescale 1ns / 1ps
module gwr_grid #(
    parameter int ADDR_W = 8,
    parameter int NUM_W  = 9
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  gwr_pkg::grid_ctl_t       ctl,
    input  logic [ADDR_W-1:0]        addr,
    input  logic [NUM_W-1:0]         num_wdata,
    input  logic [gwr_pkg::EPOCH_W-1:0] tag_wdata,
    output logic [NUM_W-1:0]         num_rdata,
    output logic [gwr_pkg::EPOCH_W-1:0] tag_rdata,
    output logic                     busy
);
    import gwr_pkg::*;

    localparam int DEPTH = 1 << ADDR_W;

    logic [NUM_W-1:0]   num_mem [DEPTH];
    logic [EPOCH_W-1:0] tag_mem [DEPTH];

    logic              busy_reg, busy_next;
    logic              clr_num_reg, clr_num_next;
    logic              clr_tag_reg, clr_tag_next;
    logic [ADDR_W-1:0] sweep_reg, sweep_next;

    assign busy = busy_reg;

    always_comb
    begin
        busy_next    = busy_reg;
        clr_num_next = clr_num_reg;
        clr_tag_next = clr_tag_reg;
        sweep_next   = sweep_reg;
        if (busy_reg)
        begin
            sweep_next = sweep_reg + 1'b1;
            if (sweep_reg == '1)
            begin
                busy_next    = 1'b0;
                clr_num_next = 1'b0;
                clr_tag_next = 1'b0;
            end
        end
        else if (ctl.clr_num || ctl.clr_tag)
        begin
            busy_next    = 1'b1;
            clr_num_next = ctl.clr_num;
            clr_tag_next = ctl.clr_tag;
            sweep_next   = '0;
        end
    end

    // reset starts a sweep over both stores
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b1;
            clr_num_reg <= 1'b1;
            clr_tag_reg <= 1'b1;
            sweep_reg   <= '0;
        end
        else
        begin
            busy_reg    <= busy_next;
            clr_num_reg <= clr_num_next;
            clr_tag_reg <= clr_tag_next;
            sweep_reg   <= sweep_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy_reg)
        begin
            if (clr_num_reg)
                num_mem[sweep_reg] <= '0;
            if (clr_tag_reg)
                tag_mem[sweep_reg] <= '0;
        end
        else
        begin
            if (ctl.num_we)
                num_mem[addr] <= num_wdata;
            if (ctl.tag_we)
                tag_mem[addr] <= tag_wdata;
            if (ctl.rd)
            begin
                num_rdata <= num_mem[addr];
                tag_rdata <= tag_mem[addr];
            end
        end
    end

endmodule

// ===== rtl/grid_walk_with_reachability_check.sv =====
`timescale 1ns / 1ps
// Grid walk with reachability check. One request gives one result. A start request sweeps
// the cell store, one entry a cycle; reset runs the same sweep over cell and mark stores
// before the first request is taken. A step runs a breadth-first search whose queue lives in
// its own memory: each pop reads the queue, a cell inside the grid is then looked up in the
// grid memory, and an open cell is expanded by marking it and writing its four neighbors to
// the queue. The pops are bounded by search_limit plus one; once every 255 searches the
// visited marks are swept first. Configuration writes land at once and grid_size counts
// from the next start.
module grid_walk_with_reachability_check #(
    parameter int MAX_SIZE    = 16,
    parameter int QUEUE_DEPTH = 4096
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  gwr_pkg::in_req_t   in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output gwr_pkg::out_rsp_t  out_data,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [gwr_pkg::CFG_W-1:0] cfg_data
);
    import gwr_pkg::*;

    localparam int RB = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
    localparam int CB = RB + 2;
    localparam int AW = 2 * RB;
    localparam int NW = $clog2(MAX_SIZE * MAX_SIZE + 1);

    fsm_t   state_reg, state_next;
    phase_t phase_reg, phase_next;

    logic [4:0]          grid_size_reg;
    logic [11:0]         walk_limit_reg;
    logic [9:0]          search_limit_reg;
    logic [RB-1:0]       walker_row_reg, walker_row_next;
    logic [RB-1:0]       walker_col_reg, walker_col_next;
    logic [NW-1:0]       step_reg, step_next;
    logic [11:0]         attempt_reg, attempt_next;
    logic [CB-2:0]       run_size_reg, run_size_next;
    logic [EPOCH_W-1:0]  epoch_reg, epoch_next;
    logic [POP_W-1:0]    pops_reg, pops_next;
    logic signed [CB-1:0] cand_row_reg, cand_row_next;
    logic signed [CB-1:0] cand_col_reg, cand_col_next;
    logic signed [CB-1:0] cur_row_reg, cur_row_next;
    logic signed [CB-1:0] cur_col_reg, cur_col_next;
    logic [1:0]          nbr_reg, nbr_next;
    logic [2:0]          status_reg, status_next;
    logic [NW-1:0]       value_reg, value_next;
    logic                out_valid_reg, out_valid_next;
    out_rsp_t            out_data_reg, out_data_next;

    grid_ctl_t           grid_ctl;
    logic [AW-1:0]       grid_addr;
    logic [NW-1:0]       grid_num_wdata, grid_num_rdata;
    logic [EPOCH_W-1:0]  grid_tag_rdata;
    logic                grid_busy;

    q_ctl_t              q_ctl;
    q_sts_t              q_sts;
    logic [2*CB-1:0]     q_wdata, q_rdata;

    logic                in_acc;
    logic                step_go;
    logic                rd_in_grid;
    logic                q_in_grid;
    logic                q_at_end;
    logic                cand_at_end;
    logic                open_cell;
    logic                can_respond;
    logic signed [CB-1:0] endc;
    logic signed [CB-1:0] walk_row_s, walk_col_s;
    logic signed [CB-1:0] q_row, q_col;
    logic signed [CB-1:0] nbr_row, nbr_col;
    logic [CB-2:0]       size_clamped;
    logic [RB+3:0]       rd_row_ext, rd_col_ext;

    gwr_grid #(
        .ADDR_W (AW),
        .NUM_W  (NW)
    ) u_grid (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (grid_ctl),
        .addr      (grid_addr),
        .num_wdata (grid_num_wdata),
        .tag_wdata (epoch_reg),
        .num_rdata (grid_num_rdata),
        .tag_rdata (grid_tag_rdata),
        .busy      (grid_busy)
    );

    gwr_queue #(
        .DEPTH (QUEUE_DEPTH),
        .DW    (2 * CB)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (q_ctl),
        .wdata (q_wdata),
        .rdata (q_rdata),
        .sts   (q_sts)
    );

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_acc    = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign endc       = $signed({1'b0, run_size_reg}) - $signed(CB'(1));
    assign walk_row_s = $signed({2'b00, walker_row_reg});
    assign walk_col_s = $signed({2'b00, walker_col_reg});
    assign q_row      = $signed(q_rdata[2*CB-1:CB]);
    assign q_col      = $signed(q_rdata[CB-1:0]);
    assign q_in_grid  = !q_row[CB-1] && !q_col[CB-1]
                        && (q_row[CB-2:0] < run_size_reg) && (q_col[CB-2:0] < run_size_reg);
    assign q_at_end   = (q_row == endc) && (q_col == endc);
    assign cand_at_end = (cand_row_reg == endc) && (cand_col_reg == endc);
    assign rd_in_grid = (in_data.read_row < run_size_reg) && (in_data.read_col < run_size_reg);
    assign rd_row_ext = (RB + 4)'(in_data.read_row);
    assign rd_col_ext = (RB + 4)'(in_data.read_col);
    assign step_go    = (phase_reg == PH_WALK) && !(attempt_reg > walk_limit_reg);
    assign open_cell  = (grid_num_rdata == '0) && (grid_tag_rdata != epoch_reg);
    assign can_respond = !out_valid_reg || !out_stall;

    always_comb
    begin
        if (grid_size_reg == 5'd0)
            size_clamped = (CB - 1)'(1);
        else if (grid_size_reg > MAX_SIZE)
            size_clamped = (CB - 1)'(MAX_SIZE);
        else
            size_clamped = (CB - 1)'(grid_size_reg);
    end

    // neighbor order: row+1, row-1, col+1, col-1
    always_comb
    begin
        nbr_row = cur_row_reg;
        nbr_col = cur_col_reg;
        case (nbr_reg)
            2'd0:    nbr_row = cur_row_reg + $signed(CB'(1));
            2'd1:    nbr_row = cur_row_reg - $signed(CB'(1));
            2'd2:    nbr_col = cur_col_reg + $signed(CB'(1));
            default: nbr_col = cur_col_reg - $signed(CB'(1));
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_INIT:
                if (!grid_busy)
                    state_next = ST_IDLE;
            ST_IDLE:
                if (in_acc)
                begin
                    case (in_data.action)
                        ACT_START: state_next = ST_CLEAR;
                        ACT_STEP:  state_next = step_go ? ST_SRCH_INIT : ST_RESP;
                        ACT_READ:  state_next = rd_in_grid ? ST_READ : ST_RESP;
                        default:   state_next = ST_RESP;
                    endcase
                end
            ST_CLEAR:
                if (!grid_busy)
                    state_next = ST_RESP;
            ST_READ:
                state_next = ST_RESP;
            ST_SRCH_INIT:
                state_next = (epoch_reg == '1) ? ST_MARK_CLR : ST_POP;
            ST_MARK_CLR:
                if (!grid_busy)
                    state_next = ST_POP;
            ST_POP:
                if (q_sts.empty || (pops_reg > POP_W'(search_limit_reg)))
                    state_next = ST_RESP;
                else
                    state_next = ST_POP_DATA;
            ST_POP_DATA:
                if (q_at_end)
                    state_next = ST_RESP;
                else if (q_in_grid)
                    state_next = ST_CHECK;
                else
                    state_next = ST_POP;
            ST_CHECK:
                state_next = open_cell ? ST_ENQ : ST_POP;
            ST_ENQ:
                if (nbr_reg == 2'd3)
                    state_next = ST_POP;
            ST_RESP:
                if (can_respond)
                    state_next = ST_IDLE;
            default:
                state_next = ST_INIT;
        endcase
    end

    always_comb
    begin
        grid_ctl        = '0;
        grid_addr       = {walker_row_reg, walker_col_reg};
        grid_num_wdata  = '0;
        q_ctl           = '0;
        q_wdata         = {cand_row_reg, cand_col_reg};
        phase_next      = phase_reg;
        walker_row_next = walker_row_reg;
        walker_col_next = walker_col_reg;
        step_next       = step_reg;
        attempt_next    = attempt_reg;
        run_size_next   = run_size_reg;
        epoch_next      = epoch_reg;
        pops_next       = pops_reg;
        cand_row_next   = cand_row_reg;
        cand_col_next   = cand_col_reg;
        cur_row_next    = cur_row_reg;
        cur_col_next    = cur_col_reg;
        nbr_next        = nbr_reg;
        status_next     = status_reg;
        value_next      = value_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_data_next   = out_data_reg;

        case (state_reg)
            ST_IDLE:
                if (in_acc)
                begin
                    status_next = STS_OK;
                    value_next  = '0;
                    case (in_data.action)
                        ACT_START:
                        begin
                            grid_ctl.clr_num = 1'b1;
                            run_size_next    = size_clamped;
                            walker_row_next  = '0;
                            walker_col_next  = '0;
                            step_next        = NW'(1);
                            attempt_next     = '0;
                            phase_next = (size_clamped == (CB - 1)'(1)) ? PH_DONE : PH_WALK;
                        end
                        ACT_STEP:
                        begin
                            if (phase_reg == PH_IDLE)
                                status_next = STS_NOT_STARTED;
                            else if (phase_reg == PH_DONE)
                                status_next = STS_FINISHED;
                            else if (phase_reg == PH_ABORT)
                                status_next = STS_ABORTED;
                            else if (!step_go)
                            begin
                                phase_next  = PH_ABORT;
                                status_next = STS_ABORTED;
                            end
                            else
                            begin
                                if (attempt_reg != 12'hFFF)
                                    attempt_next = attempt_reg + 1'b1;
                                cand_row_next = walk_row_s;
                                cand_col_next = walk_col_s;
                                case (in_data.direction)
                                    DIR_ROW_UP:   cand_row_next = walk_row_s + $signed(CB'(1));
                                    DIR_ROW_DOWN: cand_row_next = walk_row_s - $signed(CB'(1));
                                    DIR_COL_UP:   cand_col_next = walk_col_s + $signed(CB'(1));
                                    default:      cand_col_next = walk_col_s - $signed(CB'(1));
                                endcase
                                q_ctl.clear = 1'b1;
                            end
                        end
                        ACT_READ:
                            if (rd_in_grid)
                            begin
                                grid_ctl.rd = 1'b1;
                                grid_addr   = {rd_row_ext[RB-1:0], rd_col_ext[RB-1:0]};
                            end
                        default: ;
                    endcase
                end
            ST_CLEAR:
                if (!grid_busy)
                begin
                    // corner takes number one once the sweep is over
                    grid_ctl.num_we = 1'b1;
                    grid_addr       = '0;
                    grid_num_wdata  = NW'(1);
                end
            ST_READ:
                value_next = grid_num_rdata;
            ST_SRCH_INIT:
            begin
                pops_next = '0;
                if (epoch_reg == '1)
                begin
                    grid_ctl.clr_tag = 1'b1;
                    epoch_next       = EPOCH_W'(1);
                end
                else
                begin
                    epoch_next = epoch_reg + 1'b1;
                    q_ctl.push = 1'b1;
                end
            end
            ST_MARK_CLR:
                if (!grid_busy)
                    q_ctl.push = 1'b1;
            ST_POP:
                if (q_sts.empty)
                    status_next = STS_REJECTED;
                else if (pops_reg > POP_W'(search_limit_reg))
                begin
                    phase_next  = PH_ABORT;
                    status_next = STS_ABORTED;
                end
                else
                begin
                    pops_next = pops_reg + 1'b1;
                    q_ctl.pop = 1'b1;
                end
            ST_POP_DATA:
                if (q_at_end)
                begin
                    grid_ctl.num_we = 1'b1;
                    grid_addr       = {cand_row_reg[RB-1:0], cand_col_reg[RB-1:0]};
                    grid_num_wdata  = step_reg + 1'b1;
                    step_next       = step_reg + 1'b1;
                    walker_row_next = cand_row_reg[RB-1:0];
                    walker_col_next = cand_col_reg[RB-1:0];
                    if (cand_at_end)
                        phase_next = PH_DONE;
                    status_next = STS_ACCEPTED;
                end
                else if (q_in_grid)
                begin
                    grid_ctl.rd  = 1'b1;
                    grid_addr    = {q_row[RB-1:0], q_col[RB-1:0]};
                    cur_row_next = q_row;
                    cur_col_next = q_col;
                end
            ST_CHECK:
                if (open_cell)
                begin
                    grid_ctl.tag_we = 1'b1;
                    grid_addr       = {cur_row_reg[RB-1:0], cur_col_reg[RB-1:0]};
                    nbr_next        = 2'd0;
                end
            ST_ENQ:
            begin
                q_ctl.push = 1'b1;
                q_wdata    = {nbr_row, nbr_col};
                nbr_next   = nbr_reg + 1'b1;
            end
            ST_RESP:
                if (can_respond)
                begin
                    out_valid_next           = 1'b1;
                    out_data_next.status     = status_reg;
                    out_data_next.finished   = (phase_reg == PH_DONE);
                    out_data_next.pos_row    = 4'(walker_row_reg);
                    out_data_next.pos_col    = 4'(walker_col_reg);
                    out_data_next.path_count = 9'(step_reg);
                    out_data_next.cell_value = 9'(value_reg);
                end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_INIT;
            phase_reg        <= PH_IDLE;
            grid_size_reg    <= 5'd16;
            walk_limit_reg   <= 12'd1000;
            search_limit_reg <= 10'd1000;
            walker_row_reg   <= '0;
            walker_col_reg   <= '0;
            step_reg         <= '0;
            attempt_reg      <= '0;
            run_size_reg     <= '0;
            epoch_reg        <= EPOCH_W'(1);
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            phase_reg      <= phase_next;
            walker_row_reg <= walker_row_next;
            walker_col_reg <= walker_col_next;
            step_reg       <= step_next;
            attempt_reg    <= attempt_next;
            run_size_reg   <= run_size_next;
            epoch_reg      <= epoch_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_GRID_SIZE:    grid_size_reg    <= cfg_data[4:0];
                    CFG_WALK_LIMIT:   walk_limit_reg   <= cfg_data[11:0];
                    CFG_SEARCH_LIMIT: search_limit_reg <= cfg_data[9:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pops_reg     <= pops_next;
        cand_row_reg <= cand_row_next;
        cand_col_reg <= cand_col_next;
        cur_row_reg  <= cur_row_next;
        cur_col_reg  <= cur_col_next;
        nbr_reg      <= nbr_next;
        status_reg   <= status_next;
        value_reg    <= value_next;
        out_data_reg <= out_data_next;
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        grid_busy |-> !(grid_ctl.rd || grid_ctl.num_we || grid_ctl.tag_we))
        else $error("grid access during clearing sweep");

    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_DONE) |->
            ($signed({2'b00, walker_row_reg}) == endc && $signed({2'b00, walker_col_reg}) == endc))
        else $error("walk finished away from far corner");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ENQ || state_reg == ST_CHECK) |-> (phase_reg == PH_WALK))
        else $error("search running outside an active walk");

endmodule

// ===== test/grid_walk_with_reachability_check_tb.sv =====
`timescale 1ns / 1ps
module grid_walk_with_reachability_check_tb;
    import gwr_pkg::*;

    localparam logic [1:0] ACT_NOP      = 2'd3;
    localparam logic [1:0] DIR_COL_DOWN = 2'd3;
    localparam int GRID_MAX   = 16;
    localparam int QDEPTH     = 4096;
    localparam int IDLE_LIMIT = 40000;
    localparam int HOLD_LEN   = 1500;
    localparam int RAND_ITEMS = 555;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    in_req_t           in_data = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    out_rsp_t          out_data;
    logic              cfg_we = 1'b0;
    logic [1:0]        cfg_index = '0;
    logic [CFG_W-1:0]  cfg_data = '0;

    // mirror of the block state
    logic [8:0]  cell_num [0:GRID_MAX*GRID_MAX-1];
    bit          seen [0:GRID_MAX*GRID_MAX-1];
    int          fifo_r [0:QDEPTH-1];
    int          fifo_c [0:QDEPTH-1];
    int          walk_r, walk_c, step_no, attempts, side;
    phase_t      phase;
    logic [4:0]  reg_grid = 5'd16;
    logic [11:0] reg_walk = 12'd1000;
    logic [9:0]  reg_search = 10'd1000;

    out_rsp_t    pending_rsp [$];
    int          burst_left = 0;
    int          n_sent = 0, n_checked = 0, n_errors = 0, n_moves = 0, n_aborts = 0;
    int          idle_cycles = 0;
    bit          hold_req = 1'b0;

    grid_walk_with_reachability_check dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic bit on_grid(int r, int c);
        return r >= 0 && c >= 0 && r < side && c < side;
    endfunction

    // 0 far corner reachable, 1 cut off, 2 pop budget exhausted
    function automatic int flood_reach(int r0, int c0);
        int head, cnt, pops, r, c, idx, t, k;
        int dr [4];
        int dc [4];
        dr = '{1, -1, 0, 0};
        dc = '{0, 0, 1, -1};
        head = 0;
        pops = 0;
        foreach (seen[i]) seen[i] = 1'b0;
        fifo_r[0] = r0;
        fifo_c[0] = c0;
        cnt = 1;
        while (cnt > 0)
        begin
            if (pops > int'(reg_search))
                return 2;
            pops++;
            r = fifo_r[head];
            c = fifo_c[head];
            if (r == side - 1 && c == side - 1)
                return 0;
            head = (head + 1) % QDEPTH;
            cnt--;
            if (on_grid(r, c))
            begin
                idx = r * GRID_MAX + c;
                if (cell_num[idx] == 0 && !seen[idx])
                begin
                    seen[idx] = 1'b1;
                    for (k = 0; k < 4; k++)
                    begin
                        if (cnt < QDEPTH)
                        begin
                            t = (head + cnt) % QDEPTH;
                            fifo_r[t] = r + dr[k];
                            fifo_c[t] = c + dc[k];
                            cnt++;
                        end
                    end
                end
            end
        end
        return 1;
    endfunction

    function automatic out_rsp_t predict_walk(in_req_t q);
        out_rsp_t o;
        int r, c, res;
        o = '0;
        o.status = STS_OK;
        case (q.action)
            ACT_START:
            begin
                foreach (cell_num[i]) cell_num[i] = '0;
                side = (reg_grid == 0) ? 1 : (reg_grid > GRID_MAX) ? GRID_MAX : int'(reg_grid);
                cell_num[0] = 9'd1;
                walk_r = 0;
                walk_c = 0;
                step_no = 1;
                attempts = 0;
                phase = (side == 1) ? PH_DONE : PH_WALK;
            end
            ACT_STEP:
            begin
                if (phase == PH_IDLE)
                    o.status = STS_NOT_STARTED;
                else if (phase == PH_DONE)
                    o.status = STS_FINISHED;
                else if (phase == PH_ABORT)
                    o.status = STS_ABORTED;
                else if (attempts > int'(reg_walk))
                begin
                    phase = PH_ABORT;
                    o.status = STS_ABORTED;
                end
                else
                begin
                    r = walk_r;
                    c = walk_c;
                    if (attempts < 4095)
                        attempts++;
                    case (q.direction)
                        DIR_ROW_UP:   r++;
                        DIR_ROW_DOWN: r--;
                        DIR_COL_UP:   c++;
                        default:      c--;
                    endcase
                    res = flood_reach(r, c);
                    if (res == 2)
                    begin
                        phase = PH_ABORT;
                        o.status = STS_ABORTED;
                    end
                    else if (res == 0)
                    begin
                        step_no++;
                        cell_num[r * GRID_MAX + c] = step_no[8:0];
                        walk_r = r;
                        walk_c = c;
                        if (r == side - 1 && c == side - 1)
                            phase = PH_DONE;
                        o.status = STS_ACCEPTED;
                    end
                    else
                        o.status = STS_REJECTED;
                end
            end
            ACT_READ:
            begin
                if (on_grid(q.read_row, q.read_col))
                    o.cell_value = cell_num[q.read_row * GRID_MAX + q.read_col];
            end
            default: ;
        endcase
        o.finished = (phase == PH_DONE);
        o.pos_row = walk_r[3:0];
        o.pos_col = walk_c[3:0];
        o.path_count = step_no[8:0];
        return o;
    endfunction

    task automatic send_req(input int act, input int dir, input int rr, input int rc);
        in_req_t q;
        out_rsp_t e;
        q = '{action: act[1:0], direction: dir[1:0], read_row: rr[3:0], read_col: rc[3:0]};
        in_data <= q;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        e = predict_walk(q);
        pending_rsp.push_back(e);
        n_sent++;
        if (q.action == ACT_STEP && e.status == STS_ACCEPTED)
            n_moves++;
        if (q.action == ACT_STEP && e.status == STS_ABORTED)
            n_aborts++;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(0, 8);
        end
    endtask

    // hold input until every result is back
    task automatic drain;
        in_valid <= 1'b0;
        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input int value);
        drain();
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value[CFG_W-1:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_GRID_SIZE:  reg_grid = value[4:0];
            CFG_WALK_LIMIT: reg_walk = value[11:0];
            default:        reg_search = value[9:0];
        endcase
        @(posedge clk);
    endtask

    task automatic report(input string name, input int want, input int got);
        $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
    endtask

    always @(posedge clk)
    begin
        out_rsp_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_rsp.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, out_data);
                n_errors++;
            end
            else
            begin
                e = pending_rsp.pop_front();
                n_checked++;
                if (out_data !== e)
                begin
                    n_errors++;
                    if (out_data.status !== e.status)
                        report("status", e.status, out_data.status);
                    if (out_data.finished !== e.finished)
                        report("finished", e.finished, out_data.finished);
                    if (out_data.pos_row !== e.pos_row)
                        report("pos_row", e.pos_row, out_data.pos_row);
                    if (out_data.pos_col !== e.pos_col)
                        report("pos_col", e.pos_col, out_data.pos_col);
                    if (out_data.path_count !== e.path_count)
                        report("path_count", e.path_count, out_data.path_count);
                    if (out_data.cell_value !== e.cell_value)
                        report("cell_value", e.cell_value, out_data.cell_value);
                end
            end
        end
    end

    // receiver stall pattern; a hold request stalls for a long stretch
    initial
    begin
        int mode;
        int k;
        forever
        begin
            mode = $urandom_range(0, 3);
            for (k = 0; k < 64; k++)
            begin
                @(posedge clk);
                if (hold_req)
                begin
                    out_stall <= 1'b1;
                    repeat (HOLD_LEN) @(posedge clk);
                    hold_req = 1'b0;
                end
                case (mode)
                    0:       out_stall <= 1'b0;
                    1:       out_stall <= ($urandom_range(0, 9) < 3);
                    2:       out_stall <= (k % 3 == 0);
                    default: out_stall <= ($urandom_range(0, 9) < 7);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT)
        begin
            $display("%0t: no progress, %0d results outstanding", $time, pending_rsp.size());
            $display("simulation failed");
            $finish;
        end
    end

    task automatic test_before_start;
        send_req(ACT_STEP, DIR_ROW_UP, 4'd0, 4'd0);
        send_req(ACT_READ, DIR_ROW_UP, 4'd0, 4'd0);
        send_req(ACT_NOP, DIR_COL_DOWN, 4'd15, 4'd15);
    endtask

    task automatic test_size_extremes;
        write_reg(CFG_GRID_SIZE, 0);
        send_req(ACT_START, DIR_ROW_UP, 4'd0, 4'd0);
        send_req(ACT_STEP, DIR_COL_UP, 4'd0, 4'd0);
        send_req(ACT_READ, DIR_ROW_UP, 4'd0, 4'd1);
        write_reg(CFG_GRID_SIZE, 31);
        send_req(ACT_START, DIR_ROW_UP, 4'd0, 4'd0);
        send_req(ACT_STEP, DIR_COL_DOWN, 4'd0, 4'd0);
        send_req(ACT_STEP, DIR_COL_UP, 4'd0, 4'd0);
        send_req(ACT_READ, DIR_ROW_UP, 4'd15, 4'd15);
    endtask

    task automatic test_limits;
        write_reg(CFG_GRID_SIZE, 4);
        write_reg(CFG_WALK_LIMIT, 0);
        send_req(ACT_START, DIR_ROW_UP, 4'd0, 4'd0);
        send_req(ACT_STEP, DIR_ROW_UP, 4'd0, 4'd0);
        send_req(ACT_STEP, DIR_ROW_UP, 4'd0, 4'd0);
        send_req(ACT_STEP, DIR_COL_UP, 4'd0, 4'd0);
        write_reg(CFG_WALK_LIMIT, 4095);
        write_reg(CFG_SEARCH_LIMIT, 0);
        send_req(ACT_START, DIR_ROW_UP, 4'd0, 4'd0);
        send_req(ACT_STEP, DIR_COL_UP, 4'd0, 4'd0);
        write_reg(CFG_SEARCH_LIMIT, 1000);
    endtask

    task automatic test_full_walk;
        write_reg(CFG_GRID_SIZE, 3);
        send_req(ACT_START, DIR_ROW_UP, 4'd0, 4'd0);
        send_req(ACT_STEP, DIR_ROW_DOWN, 4'd0, 4'd0);
        send_req(ACT_STEP, DIR_ROW_UP, 4'd0, 4'd0);
        send_req(ACT_STEP, DIR_ROW_DOWN, 4'd0, 4'd0);
        send_req(ACT_STEP, DIR_ROW_UP, 4'd0, 4'd0);
        send_req(ACT_STEP, DIR_COL_UP, 4'd0, 4'd0);
        send_req(ACT_STEP, DIR_COL_UP, 4'd0, 4'd0);
        send_req(ACT_STEP, DIR_COL_DOWN, 4'd0, 4'd0);
        send_req(ACT_READ, DIR_ROW_UP, 4'd2, 4'd1);
        send_req(ACT_READ, DIR_ROW_UP, 4'd3, 4'd0);
    endtask

    task automatic test_backpressure;
        int k;
        write_reg(CFG_GRID_SIZE, 5);
        send_req(ACT_START, DIR_ROW_UP, 4'd0, 4'd0);
        hold_req = 1'b1;
        for (k = 0; k < 12; k++)
            send_req($urandom_range(1, 2), $urandom_range(0, 3),
                     $urandom_range(0, 15), $urandom_range(0, 15));
        drain();
    endtask

    task automatic test_random_walks;
        int pick, size_pick, len, k;
        while (n_sent < RAND_ITEMS)
        begin
            size_pick = $urandom_range(0, 9);
            if (size_pick < 7)
                write_reg(CFG_GRID_SIZE, $urandom_range(2, 6));
            else if (size_pick < 9)
                write_reg(CFG_GRID_SIZE, $urandom_range(7, 16));
            else
                write_reg(CFG_GRID_SIZE, $urandom_range(0, 1) ? $urandom_range(0, 1)
                                                              : $urandom_range(17, 31));
            write_reg(CFG_WALK_LIMIT, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 30)
                                                                 : $urandom_range(1000, 4095));
            pick = $urandom_range(0, 5);
            write_reg(CFG_SEARCH_LIMIT, (pick == 0) ? $urandom_range(0, 60) :
                                        (pick == 1) ? 1023 : 1000);
            send_req(ACT_START, $urandom_range(0, 3), $urandom_range(0, 15),
                     $urandom_range(0, 15));
            len = $urandom_range(15, 60);
            for (k = 0; k < len; k++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 34)
                    send_req(ACT_STEP, DIR_ROW_UP, $urandom_range(0, 15), $urandom_range(0, 15));
                else if (pick < 68)
                    send_req(ACT_STEP, DIR_COL_UP, $urandom_range(0, 15), $urandom_range(0, 15));
                else if (pick < 80)
                    send_req(ACT_STEP, $urandom_range(0, 3), $urandom_range(0, 15),
                             $urandom_range(0, 15));
                else if (pick < 95)
                    send_req(ACT_READ, $urandom_range(0, 3), $urandom_range(0, 15),
                             $urandom_range(0, 15));
                else if (pick < 98)
                    send_req(ACT_NOP, $urandom_range(0, 3), $urandom_range(0, 15),
                             $urandom_range(0, 15));
                else
                    send_req(ACT_START, $urandom_range(0, 3), $urandom_range(0, 15),
                             $urandom_range(0, 15));
            end
        end
    endtask

    initial
    begin
        foreach (cell_num[i]) cell_num[i] = '0;
        walk_r = 0;
        walk_c = 0;
        step_no = 0;
        attempts = 0;
        side = GRID_MAX;
        phase = PH_IDLE;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_before_start();
        test_size_extremes();
        test_limits();
        test_full_walk();
        test_backpressure();
        test_random_walks();
        drain();
        repeat (100) @(posedge clk);
        $display("Sent %0d requests, checked %0d results: %0d moves taken, %0d aborts.",
                 n_sent, n_checked, n_moves, n_aborts);
        $display("Grid sizes 1 to 16 with clamped writes, walk and search limits at extremes.");
        if (n_errors == 0 && pending_rsp.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
